// File: src/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC16 byte step of the framed packet
// receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   // Event queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Width of the idle tick counter and of the timeout register.
   localparam int TIMEOUT_BITS = 24;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_MAX_LEN    = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]              START_BYTE_RST = 8'hAA;
   localparam logic [7:0]              MAX_LEN_RST    = 8'd68;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST    = TIMEOUT_BITS'(200000);

   // Result kinds and end status codes.
   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_END     = 1'b1;
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

   // Input op codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // CRC16-CCITT parameters.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   // One classified event as the front hands it to the back.
   typedef struct packed {
      logic       is_tick;
      logic [7:0] rx_byte;
   } evt_type;

   // Head of the event queue.
   typedef struct packed {
      logic    valid;
      evt_type evt;
   } head_type;

   // CRC16 update by one byte, MSB first.
   function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: src/crcfr_queue.sv
// ----------------------------------------------------------------------------
// crcfr_queue
// Front of the receiver: accepts input events, classifies them as byte or
// tick and holds them in a short queue for the frame engine.
// ----------------------------------------------------------------------------
module crcfr_queue
   import crcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_rx_byte,
   output head_type   head,
   input  logic       pop
);

   evt_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   evt_type           push_evt;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      push_evt.is_tick = (req_op == OP_TICK);
      push_evt.rx_byte = req_rx_byte;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_evt;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.evt   = mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

// File: src/crcfr_engine.sv
// ----------------------------------------------------------------------------
// crcfr_engine
// Back of the receiver: runs the deframing state machine on queued events,
// keeps the running CRC and the idle count, holds the configuration
// registers and drives the result register.
// ----------------------------------------------------------------------------
module crcfr_engine
   import crcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   input  logic       csr_valid,
   input  logic [1:0] csr_index,
   input  logic [23:0] csr_wdata,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_length,
   output logic [7:0] rsp_data,
   output logic [7:0] rsp_byte_index,
   output logic [1:0] rsp_status
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_CMD    = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CRC_HI = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;

   localparam logic [TIMEOUT_BITS-1:0] IDLE_MAX = '1;

   // Configuration.
   logic [7:0]              start_byte_ff;
   logic [7:0]              max_len_ff;
   logic [TIMEOUT_BITS-1:0] timeout_ff;

   // Frame state.
   logic [2:0]              phase_ff, phase_in;
   logic [15:0]             crc_ff, crc_in;
   logic [7:0]              command_ff, command_in;
   logic [7:0]              length_ff, length_in;
   logic [7:0]              count_ff, count_in;
   logic [7:0]              check_hi_ff, check_hi_in;
   logic [TIMEOUT_BITS-1:0] idle_ff, idle_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] rcmd_ff, rcmd_in;
   logic [7:0] rlen_ff, rlen_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] index_ff, index_in;
   logic [1:0] status_ff, status_in;

   logic                    out_free;
   logic                    emit;
   logic                    in_frame;
   logic [7:0]              b;
   logic [15:0]             crc_next;
   logic [TIMEOUT_BITS-1:0] idle_inc;
   logic [7:0]              count_inc;

   // A new event is taken whenever the result register is empty or its
   // result leaves in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;

   assign b         = head.evt.rx_byte;
   assign crc_next  = crc_step(crc_ff, b);
   assign idle_inc  = (idle_ff < IDLE_MAX) ? idle_ff + 1'b1 : idle_ff;
   assign count_inc = count_ff + 1'b1;
   assign in_frame  = (phase_ff >= PH_CMD) && (phase_ff <= PH_CRC_LO);

   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      check_hi_in = check_hi_ff;
      idle_in     = idle_ff;
      emit        = 1'b0;
      kind_in     = kind_ff;
      data_in     = data_ff;
      index_in    = index_ff;
      status_in   = status_ff;

      if (pop) begin
         if (!in_frame) begin
            phase_in = PH_HUNT;
         end
         if (head.evt.is_tick) begin
            if (in_frame) begin
               idle_in = idle_inc;
               if (idle_inc > timeout_ff) begin
                  emit      = 1'b1;
                  kind_in   = KIND_END;
                  status_in = STATUS_TIMEOUT;
                  phase_in  = PH_HUNT;
                  idle_in   = '0;
               end
            end
         end else begin
            idle_in = '0;
            case (phase_ff)
               PH_CMD: begin
                  command_in = b;
                  crc_in     = crc_next;
                  phase_in   = PH_LEN;
               end
               PH_LEN: begin
                  length_in = b;
                  crc_in    = crc_next;
                  if (b > max_len_ff) begin
                     emit      = 1'b1;
                     kind_in   = KIND_END;
                     status_in = STATUS_TOO_LONG;
                     phase_in  = PH_HUNT;
                  end else begin
                     count_in = '0;
                     phase_in = (b == 8'd0) ? PH_CRC_HI : PH_DATA;
                  end
               end
               PH_DATA: begin
                  crc_in    = crc_next;
                  count_in  = count_inc;
                  emit      = 1'b1;
                  kind_in   = KIND_PAYLOAD;
                  status_in = STATUS_OK;
                  data_in   = b;
                  index_in  = count_ff;
                  if (count_inc >= length_ff) begin
                     phase_in = PH_CRC_HI;
                  end
               end
               PH_CRC_HI: begin
                  check_hi_in = b;
                  phase_in    = PH_CRC_LO;
               end
               PH_CRC_LO: begin
                  emit      = 1'b1;
                  kind_in   = KIND_END;
                  status_in = ({check_hi_ff, b} == crc_ff) ? STATUS_OK : STATUS_CRC_BAD;
                  phase_in  = PH_HUNT;
               end
               default: begin
                  if (b == start_byte_ff) begin
                     phase_in    = PH_CMD;
                     crc_in      = CRC_INIT;
                     command_in  = '0;
                     length_in   = '0;
                     count_in    = '0;
                     check_hi_in = '0;
                  end
               end
            endcase
         end
      end

      if (emit && kind_in == KIND_END) begin
         data_in  = '0;
         index_in = '0;
      end
      rcmd_in = command_in;
      rlen_in = length_in;

      if (pop) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         max_len_ff    <= MAX_LEN_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wdata[7:0];
            CSR_MAX_LEN:    max_len_ff    <= csr_wdata[7:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata[TIMEOUT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         crc_ff       <= CRC_INIT;
         command_ff   <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         check_hi_ff  <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         check_hi_ff  <= check_hi_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= kind_in;
         rcmd_ff   <= rcmd_in;
         rlen_ff   <= rlen_in;
         data_ff   <= data_in;
         index_ff  <= index_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_command    = rcmd_ff;
   assign rsp_length     = rlen_ff;
   assign rsp_data       = data_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_status     = status_ff;

`ifndef SYNTHESIS
   a_hunt_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (idle_ff == '0))
      else $error("idle count running while hunting");

   a_end_returns_hunt: assert property (@(posedge clock) disable iff (reset)
      (emit && kind_in == KIND_END) |=> (phase_ff == PH_HUNT))
      else $error("frame end did not return to hunting");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_PAYLOAD) |->
         (status_ff == STATUS_OK && index_ff < rlen_ff))
      else $error("payload result with bad status or index");
`endif

endmodule

// File: src/crc16_framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// crc16_framed_packet_receiver_core
// Deframer for start / command / length / payload / CRC16 frames arriving as
// serial bytes and tick events; forwards payload cut-through and closes each
// frame with one status result.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  op, rx_byte
//   rsp_     out        rsp_valid/rsp_stall  kind, command, length, data,
//                                            byte_index, status
//   csr_     in         csr_valid/csr_ready  index, wdata (ready always high)
//
// One event per cycle is sustained while the result side does not stall.
// An event is written into the four-entry event queue at its transfer; the
// frame engine with its unrolled eight-bit CRC step then takes it from the
// queue head and loads its result into the result register, which holds it
// until it transfers. Reset is synchronous and active high.
// A stall on the result side fills the queue, which then stalls the input.
// ----------------------------------------------------------------------------
module crc16_framed_packet_receiver_core
   import crcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_length,
   output logic [7:0]  rsp_data,
   output logic [7:0]  rsp_byte_index,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   head_type head;
   logic     pop;

   assign csr_ready = 1'b1;

   crcfr_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .head        (head),
      .pop         (pop)
   );

   crcfr_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_command    (rsp_command),
      .rsp_length     (rsp_length),
      .rsp_data       (rsp_data),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status)
   );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed packet receiver. A queue-fed driver
// sends byte and tick events, and a local deframer predicts the payload and
// end-of-frame results. A monitor checks each result transfer in order while
// both sides pause at random. The run covers directed frames, several
// register settings and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import crcfr_pkg::*;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam int         ITEM_TARGET    = 550;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         LONG_HOLD      = 150;
   localparam int         WATCHDOG_LIMIT = 3000;

   localparam logic [2:0] RX_HUNT   = 3'd0;
   localparam logic [2:0] RX_CMD    = 3'd1;
   localparam logic [2:0] RX_LEN    = 3'd2;
   localparam logic [2:0] RX_DATA   = 3'd3;
   localparam logic [2:0] RX_CRC_HI = 3'd4;
   localparam logic [2:0] RX_CRC_LO = 3'd5;

   typedef enum int {FRAME_CLEAN, FRAME_BAD_CRC, FRAME_CUT_SHORT} frame_flaw_type;

   typedef struct {
      logic       op;
      logic [7:0] value;
   } rx_event_type;

   typedef struct {
      logic       kind;
      logic [7:0] command;
      logic [7:0] length;
      logic [7:0] data;
      logic [7:0] byte_index;
      logic [1:0] status;
   } frame_result_type;

   typedef logic [7:0] byte_q_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_length;
   logic [7:0]  rsp_data;
   logic [7:0]  rsp_byte_index;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_START_BYTE;
   logic [23:0] csr_wdata = 24'h000000;

   crc16_framed_packet_receiver_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_command    (rsp_command),
      .rsp_length     (rsp_length),
      .rsp_data       (rsp_data),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies, updated when a write transfer completes.
   logic [7:0]              cfg_start   = START_BYTE_RST;
   logic [7:0]              cfg_max_len = MAX_LEN_RST;
   logic [TIMEOUT_BITS-1:0] cfg_timeout = TIMEOUT_RST;

   // Deframer state as the block should hold it.
   logic [2:0]              rx_phase    = RX_HUNT;
   logic [15:0]             running_crc = CRC_INIT;
   logic [7:0]              frame_cmd   = 8'h00;
   logic [7:0]              frame_len   = 8'h00;
   logic [7:0]              body_count  = 8'h00;
   logic [7:0]              crc_high    = 8'h00;
   logic [TIMEOUT_BITS-1:0] idle_ticks  = '0;

   rx_event_type     rx_events_pending[$];
   frame_result_type deframer_results_due[$];

   int unsigned err_count     = 0;
   int unsigned events_queued = 0;
   int          hold_asks     = 0;
   int          hold_served   = 0;
   bit          gaps_off      = 1'b0;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = c[15] ^ b[k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int pick_idle();
      int r;
      if (gaps_off) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic note_mismatch(input string what);
      err_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want_v);
      if (got != want_v) begin
         note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want_v));
      end
   endtask

   task automatic expect_result(input logic kind, input logic [7:0] data,
                                input logic [7:0] index, input logic [1:0] status);
      frame_result_type res;
      res.kind       = kind;
      res.command    = frame_cmd;
      res.length     = frame_len;
      res.data       = data;
      res.byte_index = index;
      res.status     = status;
      deframer_results_due.push_back(res);
   endtask

   task automatic close_frame(input logic [1:0] status);
      rx_phase   = RX_HUNT;
      idle_ticks = '0;
      expect_result(KIND_END, 8'h00, 8'h00, status);
   endtask

   // Advances the deframer by one accepted event.
   task automatic deframe_step(input logic op, input logic [7:0] b);
      if (op == OP_TICK) begin
         if (rx_phase == RX_HUNT) begin
            return;
         end
         if (idle_ticks != '1) begin
            idle_ticks++;
         end
         if (idle_ticks > cfg_timeout) begin
            close_frame(STATUS_TIMEOUT);
         end
         return;
      end
      idle_ticks = '0;
      case (rx_phase)
         RX_HUNT: begin
            if (b == cfg_start) begin
               rx_phase    = RX_CMD;
               running_crc = CRC_INIT;
               frame_cmd   = 8'h00;
               frame_len   = 8'h00;
               body_count  = 8'h00;
               crc_high    = 8'h00;
            end
         end
         RX_CMD: begin
            frame_cmd   = b;
            running_crc = crc16_byte(running_crc, b);
            rx_phase    = RX_LEN;
         end
         RX_LEN: begin
            frame_len   = b;
            running_crc = crc16_byte(running_crc, b);
            if (b > cfg_max_len) begin
               close_frame(STATUS_TOO_LONG);
            end else begin
               body_count = 8'h00;
               rx_phase   = (b == 8'h00) ? RX_CRC_HI : RX_DATA;
            end
         end
         RX_DATA: begin
            expect_result(KIND_PAYLOAD, b, body_count, STATUS_OK);
            running_crc = crc16_byte(running_crc, b);
            body_count++;
            if (body_count >= frame_len) begin
               rx_phase = RX_CRC_HI;
            end
         end
         RX_CRC_HI: begin
            crc_high = b;
            rx_phase = RX_CRC_LO;
         end
         RX_CRC_LO: begin
            close_frame(({crc_high, b} == running_crc) ? STATUS_OK : STATUS_CRC_BAD);
         end
         default: rx_phase = RX_HUNT;
      endcase
   endtask

   // Driver: holds a stalled event, otherwise pauses or offers the next one.
   int gap_left = 0;

   always @(posedge clock) begin
      rx_event_type ev;
      if (reset) begin
         req_valid   <= 1'b0;
         req_op      <= OP_BYTE;
         req_rx_byte <= 8'h00;
         gap_left    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_step(req_op, req_rx_byte);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_events_pending.size() > 0) begin
               ev = rx_events_pending.pop_front();
               req_valid   <= 1'b1;
               req_op      <= ev.op;
               req_rx_byte <= ev.value;
               gap_left    = pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and decides the next stall.
   int stall_left = 0;

   always @(posedge clock) begin
      frame_result_type want;
      int               idle;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframer_results_due.size() == 0) begin
               note_mismatch("result transfer with nothing expected");
            end else begin
               want = deframer_results_due.pop_front();
               check_field("kind", rsp_kind, want.kind);
               check_field("command", rsp_command, want.command);
               check_field("length", rsp_length, want.length);
               check_field("data", rsp_data, want.data);
               check_field("byte_index", rsp_byte_index, want.byte_index);
               check_field("status", rsp_status, want.status);
            end
         end
         if (hold_asks != hold_served) begin
            hold_served++;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            idle = pick_idle();
            if (idle > 0) begin
               stall_left = idle - 1;
               rsp_stall  <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer on any channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no transfer in %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         CSR_START_BYTE: cfg_start   = value[7:0];
         CSR_MAX_LEN:    cfg_max_len = value[7:0];
         CSR_TIMEOUT:    cfg_timeout = value[TIMEOUT_BITS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic add_event(input logic op, input logic [7:0] b);
      rx_event_type ev;
      ev.op    = op;
      ev.value = b;
      rx_events_pending.push_back(ev);
      events_queued++;
   endtask

   // The byte field of a tick is don't-care, so it carries noise.
   task automatic add_tick();
      add_event(OP_TICK, 8'($urandom));
   endtask

   // A few ticks between frame bytes, never enough to trip the timeout.
   task automatic inter_ticks(input int pct);
      int n;
      if ($urandom_range(0, 99) < pct) begin
         n = (cfg_timeout < 3) ? int'(cfg_timeout) : 3;
         repeat ($urandom_range(1, n)) add_tick();
      end
   endtask

   task automatic queue_frame(input logic [7:0] cmd, input byte_q_type body,
                              input frame_flaw_type flaw, input int tick_pct);
      logic [15:0] crc;
      byte_q_type  rest;
      int          keep;
      add_event(OP_BYTE, cfg_start);
      inter_ticks(tick_pct);
      add_event(OP_BYTE, cmd);
      crc = crc16_byte(CRC_INIT, cmd);
      inter_ticks(tick_pct);
      add_event(OP_BYTE, 8'(body.size()));
      crc = crc16_byte(crc, 8'(body.size()));
      foreach (body[i]) begin
         crc = crc16_byte(crc, body[i]);
      end
      if (flaw == FRAME_BAD_CRC) begin
         crc = crc ^ 16'($urandom_range(1, 65535));
      end
      rest = body;
      rest.push_back(crc[15:8]);
      rest.push_back(crc[7:0]);
      keep = rest.size();
      if (flaw == FRAME_CUT_SHORT) begin
         keep = $urandom_range(0, rest.size() - 1);
      end
      for (int k = 0; k < keep; k++) begin
         inter_ticks(tick_pct);
         add_event(OP_BYTE, rest[k]);
      end
      if (flaw == FRAME_CUT_SHORT) begin
         repeat (int'(cfg_timeout) + 1) add_tick();
      end
   endtask

   task automatic queue_oversize(input logic [7:0] cmd, input logic [7:0] len);
      add_event(OP_BYTE, cfg_start);
      add_event(OP_BYTE, cmd);
      add_event(OP_BYTE, len);
   endtask

   // Mostly well-formed frames with random content, plus noise and bad frames.
   task automatic random_frames(input int budget);
      int             first;
      int             r;
      int             lim;
      logic [7:0]     b;
      byte_q_type     body;
      frame_flaw_type flaw;
      first = events_queued;
      while (events_queued - first < budget) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0) begin
                  add_tick();
               end else begin
                  b = 8'($urandom);
                  if (b == cfg_start) begin
                     b = b + 8'd1;
                  end
                  add_event(OP_BYTE, b);
               end
            end
         end else if (r < 16 && cfg_max_len < 8'd255) begin
            queue_oversize(8'($urandom), 8'($urandom_range(cfg_max_len + 1, 255)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               lim = (cfg_max_len < 12) ? int'(cfg_max_len) : 12;
            end else if (r < 95) begin
               lim = (cfg_max_len < 40) ? int'(cfg_max_len) : 40;
            end else begin
               lim = cfg_max_len;
            end
            body = {};
            repeat ($urandom_range(0, lim)) body.push_back(8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 12) begin
               flaw = FRAME_BAD_CRC;
            end else if (r < 22 && cfg_timeout <= 16) begin
               flaw = FRAME_CUT_SHORT;
            end else begin
               flaw = FRAME_CLEAN;
            end
            queue_frame(8'($urandom), body, flaw, 10);
         end
      end
   endtask

   // Waits until every event is taken and every result checked, then lets
   // events that cause no result leave the pipeline.
   task automatic drain_block();
      @(negedge clock);
      while (rx_events_pending.size() != 0 || req_valid ||
             deframer_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      byte_q_type body;
      logic [7:0] max_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: noise while hunting, a zero-length frame, the start
      // byte inside a payload, a bad check and an oversized length.
      add_event(OP_BYTE, 8'h00);
      add_event(OP_BYTE, 8'hFF);
      add_tick();
      body = {};
      queue_frame(8'hFF, body, FRAME_CLEAN, 0);
      body = '{8'h00, 8'hFF, 8'hAA};
      queue_frame(8'h00, body, FRAME_CLEAN, 40);
      body = '{8'h42};
      queue_frame(8'h5A, body, FRAME_BAD_CRC, 0);
      queue_oversize(8'h01, 8'd69);
      drain_block();

      // Lowest settings; upper data bits of the byte registers are junk.
      write_csr(CSR_START_BYTE, 24'hC3A500);
      write_csr(CSR_MAX_LEN, 24'h5A5A00);
      write_csr(CSR_TIMEOUT, 24'd1);
      write_csr(CSR_UNUSED, 24'hFFFFFF);
      @(negedge clock);
      body = {};
      queue_frame(8'h7E, body, FRAME_CLEAN, 0);
      queue_oversize(8'h7E, 8'h01);
      // Timeout before the command byte, then one while waiting for the CRC.
      add_event(OP_BYTE, 8'h00);
      add_tick();
      add_tick();
      add_event(OP_BYTE, 8'h00);
      add_event(OP_BYTE, 8'h11);
      add_tick();
      add_event(OP_BYTE, 8'h00);
      add_tick();
      add_tick();
      random_frames(60);
      drain_block();

      // Highest settings. A full-size frame goes in while the receiver holds
      // off, so the block backs up into its input.
      write_csr(CSR_START_BYTE, 24'h0000FF);
      write_csr(CSR_MAX_LEN, 24'h0000FF);
      write_csr(CSR_TIMEOUT, 24'hFFFFFF);
      @(negedge clock);
      gaps_off = 1'b1;
      hold_asks++;
      body = {};
      repeat (255) body.push_back(8'($urandom));
      queue_frame(8'($urandom), body, FRAME_CLEAN, 5);
      drain_block();
      gaps_off = 1'b0;
      random_frames(40);
      drain_block();

      while (events_queued < ITEM_TARGET) begin
         write_csr(CSR_START_BYTE, 24'($urandom));
         if ($urandom_range(0, 99) < 75) begin
            max_len = 8'($urandom_range(0, 12));
         end else begin
            max_len = 8'($urandom_range(13, 255));
         end
         write_csr(CSR_MAX_LEN, {16'($urandom), max_len});
         if ($urandom_range(0, 99) < 80) begin
            write_csr(CSR_TIMEOUT, 24'($urandom_range(1, 6)));
         end else begin
            write_csr(CSR_TIMEOUT, 24'($urandom_range(7, 20000)));
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_UNUSED, 24'($urandom));
         end
         @(negedge clock);
         gaps_off = ($urandom_range(0, 3) == 0);
         random_frames($urandom_range(40, 90));
         drain_block();
      end
      gaps_off = 1'b0;

      if (err_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
